/* rtl/bba_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the buddy block allocator.
// No dependencies; used by every module of the block.
package bba_pkg;

    localparam int TOTAL_LOG2_DEF = 10;
    localparam int REQ_W          = 11;
    localparam int OFF_W          = 10;
    localparam int ST_W           = 2;

    typedef logic [1:0] t_node;
    localparam t_node ND_UNUSED = 2'd0;
    localparam t_node ND_FREE   = 2'd1;
    localparam t_node ND_ALLOC  = 2'd2;
    localparam t_node ND_SPLIT  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADSIZE = 2'd2;
    localparam logic [ST_W-1:0] ST_BADFREE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;

    typedef logic [1:0] t_tgt;
    localparam t_tgt TGT_SELF   = 2'd0;
    localparam t_tgt TGT_RIGHT  = 2'd1;
    localparam t_tgt TGT_PARENT = 2'd2;
    localparam t_tgt TGT_ROOT   = 2'd3;

    typedef logic [2:0] t_mv;
    localparam t_mv MV_HOLD  = 3'd0;
    localparam t_mv MV_LEFT  = 3'd1;
    localparam t_mv MV_BYOFF = 3'd2;
    localparam t_mv MV_NEXT  = 3'd3;
    localparam t_mv MV_UP    = 3'd4;

    typedef struct packed {
        logic            load;
        logic            sel_sib;
        logic            wr_en;
        t_tgt            wr_tgt;
        t_node           wr_code;
        t_mv             mv;
        logic            fin;
        logic [ST_W-1:0] fin_st;
    } t_dp_cmd;

    typedef struct packed {
        t_node code;
        logic  op;
        logic  fit;
        logic  big;
        logic  big1;
        logic  leaf_max;
        logic  root;
        logic  nxt_end;
        logic  req_zero;
        logic  req_big;
        logic  off_bad;
        logic  match;
        logic  out_busy;
    } t_dp_sts;

    // smallest k with 2**k >= req, for req >= 1
    function automatic logic [3:0] ceil_log2_req(input logic [REQ_W-1:0] req);
        logic [REQ_W-1:0] v;
        logic [3:0]       r;
        v = req - REQ_W'(1);
        r = 4'd0;
        for (int i = 0; i < REQ_W; i++) begin
            if (v[i]) r = 4'(i + 1);
        end
        return r;
    endfunction

endpackage

/* rtl/bba_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on bba_pkg for field widths.
interface bba_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [bba_pkg::REQ_W-1:0]   request_size;
    logic [bba_pkg::OFF_W-1:0]   block_offset;
    modport source (output valid, operation, request_size, block_offset, input ready);
    modport sink   (input valid, operation, request_size, block_offset, output ready);
endinterface

interface bba_out_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::ST_W-1:0]    status;
    logic [bba_pkg::OFF_W-1:0]   result_offset;
    logic [bba_pkg::REQ_W-1:0]   result_size;
    modport source (output valid, status, result_offset, result_size, input ready);
    modport sink   (input valid, status, result_offset, result_size, output ready);
endinterface

/* rtl/bba_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for search, split, descent and merge walks.
// Depends on bba_pkg; drives bba_dpath through command/status structs.
module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bba_pkg::t_dp_sts  i_sts,
    output bba_pkg::t_dp_cmd  o_cmd
);
    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_ACHK   = 4'd3;
    localparam logic [3:0] S_AWAIT  = 4'd4;
    localparam logic [3:0] S_SPL1   = 4'd5;
    localparam logic [3:0] S_SPL2   = 4'd6;
    localparam logic [3:0] S_AALLOC = 4'd7;
    localparam logic [3:0] S_FCHK   = 4'd8;
    localparam logic [3:0] S_FWAIT  = 4'd9;
    localparam logic [3:0] S_MTEST  = 4'd10;
    localparam logic [3:0] S_MCHK   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE) && !i_sts.out_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.wr_tgt  = bba_pkg::TGT_SELF;
        o_cmd.mv      = bba_pkg::MV_HOLD;
        o_cmd.fin_st  = bba_pkg::ST_OK;
        o_cmd.load    = accept;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_tgt  = bba_pkg::TGT_ROOT;
                o_cmd.wr_code = bba_pkg::ND_FREE;
                n_state       = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.op == bba_pkg::OP_ALLOC) begin
                    if (i_sts.req_zero) begin
                        o_cmd.fin    = 1'b1;
                        o_cmd.fin_st = bba_pkg::ST_BADSIZE;
                        n_state      = S_IDLE;
                    end else if (i_sts.req_big) begin
                        o_cmd.fin    = 1'b1;
                        o_cmd.fin_st = bba_pkg::ST_NOFIT;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_ACHK;
                    end
                end else if (i_sts.off_bad) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.fin_st = bba_pkg::ST_BADFREE;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_ACHK: begin
                if (i_sts.code == bba_pkg::ND_FREE && i_sts.fit) begin
                    n_state = i_sts.big ? S_SPL1 : S_AALLOC;
                end else if (i_sts.code == bba_pkg::ND_SPLIT && i_sts.big) begin
                    o_cmd.mv = bba_pkg::MV_LEFT;
                    n_state  = S_AWAIT;
                end else if (i_sts.nxt_end) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.fin_st = bba_pkg::ST_NOFIT;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.mv = bba_pkg::MV_NEXT;
                    n_state  = S_AWAIT;
                end
            end
            S_AWAIT: n_state = S_ACHK;
            S_SPL1: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_code = bba_pkg::ND_SPLIT;
                n_state       = S_SPL2;
            end
            S_SPL2: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_tgt  = bba_pkg::TGT_RIGHT;
                o_cmd.wr_code = bba_pkg::ND_FREE;
                o_cmd.mv      = bba_pkg::MV_LEFT;
                n_state       = i_sts.big1 ? S_SPL1 : S_AALLOC;
            end
            S_AALLOC: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_code = bba_pkg::ND_ALLOC;
                o_cmd.fin     = 1'b1;
                n_state       = S_IDLE;
            end
            S_FCHK: begin
                if (i_sts.code == bba_pkg::ND_SPLIT && !i_sts.leaf_max) begin
                    o_cmd.mv = bba_pkg::MV_BYOFF;
                    n_state  = S_FWAIT;
                end else if (i_sts.code == bba_pkg::ND_ALLOC && i_sts.match) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_code = bba_pkg::ND_FREE;
                    n_state       = S_MTEST;
                end else begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.fin_st = bba_pkg::ST_BADFREE;
                    n_state      = S_IDLE;
                end
            end
            S_FWAIT: n_state = S_FCHK;
            S_MTEST: begin
                if (i_sts.root) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.sel_sib = 1'b1;
                    n_state       = S_MCHK;
                end
            end
            S_MCHK: begin
                if (i_sts.code == bba_pkg::ND_FREE) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_tgt  = bba_pkg::TGT_PARENT;
                    o_cmd.wr_code = bba_pkg::ND_FREE;
                    o_cmd.mv      = bba_pkg::MV_UP;
                    n_state       = S_MTEST;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* rtl/bba_dpath.sv */
`timescale 1ns / 1ps
// Datapath: node-status memory, block cursor, request and result registers.
// Depends on bba_pkg; commanded by bba_ctrl.
module bba_dpath #(
    parameter int TOTAL_LOG2 = bba_pkg::TOTAL_LOG2_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bba_pkg::t_dp_cmd              i_cmd,
    output bba_pkg::t_dp_sts              o_sts,
    input  logic                          i_operation,
    input  logic [bba_pkg::REQ_W-1:0]     i_request_size,
    input  logic [bba_pkg::OFF_W-1:0]     i_block_offset,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bba_pkg::ST_W-1:0]      o_status,
    output logic [bba_pkg::OFF_W-1:0]     o_result_offset,
    output logic [bba_pkg::REQ_W-1:0]     o_result_size
);
    localparam int L     = TOTAL_LOG2;
    localparam int DW    = $clog2(L + 1);
    localparam int NW    = L + 1;
    localparam int NODES = (2 ** (L + 1)) - 1;
    localparam int WW    = (L + 1 > bba_pkg::REQ_W) ? L + 1 : bba_pkg::REQ_W;

    logic                       r_op;
    logic [bba_pkg::REQ_W-1:0]  r_req;
    logic [bba_pkg::OFF_W-1:0]  r_off;
    logic [DW-1:0]              r_k;
    logic [L-1:0]               r_b;
    logic [DW-1:0]              r_d;
    bba_pkg::t_node             mem [NODES];
    bba_pkg::t_node             r_rdata;
    logic                       r_ov;
    logic [bba_pkg::ST_W-1:0]   r_ost;
    logic [bba_pkg::OFF_W-1:0]  r_ooff;
    logic [bba_pkg::REQ_W-1:0]  r_osize;

    logic [DW-1:0]  slog;
    logic [L-1:0]   bit_s;
    logic [L-1:0]   bit_h;
    logic [L:0]     bn;
    logic [DW-1:0]  tz;
    logic [WW-1:0]  offw;
    logic [WW-1:0]  capw;
    logic [WW-1:0]  bw;
    logic [WW-1:0]  szw;
    logic [L-1:0]   offl;
    logic [NW-1:0]  waddr;
    logic [NW-1:0]  raddr;
    logic           fin_ok;

    function automatic logic [NW-1:0] node_idx(input logic [L-1:0] b, input logic [DW-1:0] d);
        logic [DW-1:0] sh;
        sh = DW'(L) - d;
        return ((NW'(1) << d) - NW'(1)) + (NW'(b) >> sh);
    endfunction

    assign slog  = DW'(L) - r_d;
    assign bit_s = L'(1) << slog;
    assign bit_h = L'(1) << (slog - DW'(1));
    assign bn    = {1'b0, r_b} + ((NW'(1)) << slog);
    assign offw  = WW'(r_off);
    assign offl  = offw[L-1:0];
    assign capw  = WW'(1) << L;
    assign bw    = WW'(r_b);
    assign szw   = WW'(1) << slog;

    always_comb begin
        tz = '0;
        for (int i = L - 1; i >= 0; i--) begin
            if (bn[i]) tz = DW'(i);
        end
    end

    always_comb begin
        case (i_cmd.wr_tgt)
            bba_pkg::TGT_SELF:   waddr = node_idx(r_b, r_d);
            bba_pkg::TGT_RIGHT:  waddr = node_idx(r_b | bit_h, r_d + DW'(1));
            bba_pkg::TGT_PARENT: waddr = node_idx(r_b & ~bit_s, r_d - DW'(1));
            default:             waddr = '0;
        endcase
    end

    assign raddr = i_cmd.sel_sib ? node_idx(r_b ^ bit_s, r_d) : node_idx(r_b, r_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) mem[waddr] <= i_cmd.wr_code;
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_req <= i_request_size;
            r_off <= i_block_offset;
            r_k   <= DW'(bba_pkg::ceil_log2_req(i_request_size));
            r_b   <= '0;
            r_d   <= '0;
        end else begin
            case (i_cmd.mv)
                bba_pkg::MV_LEFT: begin
                    r_d <= r_d + DW'(1);
                end
                bba_pkg::MV_BYOFF: begin
                    if (|(offl & bit_h)) r_b <= r_b | bit_h;
                    r_d <= r_d + DW'(1);
                end
                bba_pkg::MV_NEXT: begin
                    r_b <= bn[L-1:0];
                    r_d <= DW'(L) - tz;
                end
                bba_pkg::MV_UP: begin
                    r_b <= r_b & ~bit_s;
                    r_d <= r_d - DW'(1);
                end
                default: begin
                    r_b <= r_b;
                end
            endcase
        end
    end

    assign fin_ok = (i_cmd.fin_st == bba_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_ost   <= i_cmd.fin_st;
            r_ooff  <= fin_ok ? bw[bba_pkg::OFF_W-1:0] : '0;
            r_osize <= fin_ok ? szw[bba_pkg::REQ_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_ost;
    assign o_result_offset = r_ooff;
    assign o_result_size   = r_osize;

    always_comb begin
        o_sts          = '0;
        o_sts.code     = r_rdata;
        o_sts.op       = r_op;
        o_sts.fit      = slog >= r_k;
        o_sts.big      = slog > r_k;
        o_sts.big1     = {1'b0, slog} > ({1'b0, r_k} + (DW + 1)'(1));
        o_sts.leaf_max = (r_d == DW'(L));
        o_sts.root     = (r_d == '0);
        o_sts.nxt_end  = bn[L];
        o_sts.req_zero = (r_req == '0);
        o_sts.req_big  = WW'(r_req) > capw;
        o_sts.off_bad  = offw >= capw;
        o_sts.match    = (r_b == offl);
        o_sts.out_busy = r_ov && !i_ready;
    end
endmodule

/* rtl/buddy_block_allocator.sv */
`timescale 1ns / 1ps
// Buddy block allocator top level: controller, datapath and channel ports.
// Depends on bba_pkg, bba_if, bba_ctrl and bba_dpath.
// One transaction at a time. Every tree node visited after the first waits on the
// registered read of the node-status memory, which has one write and one read port.
// An allocate runs a lowest-offset search for a free block that fits, then splits
// it down to the request size and marks the block allocated; a failed search
// answers no-fit. A free descends by offset, frees the matching allocated block
// and merges free buddies upward until a buddy is not free or the root is
// reached; an offset with no matching block is rejected after the descent.
// Rejected sizes and out-of-range offsets answer from the dispatch state. After
// reset the root is initialized before the first request is taken. The result
// sits in an output register, and the next request is taken in the cycle the
// result is consumed.
module buddy_block_allocator #(
    parameter int TOTAL_LOG2 = bba_pkg::TOTAL_LOG2_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_in_if.sink    i_in,
    bba_out_if.source o_out
);
    bba_pkg::t_dp_cmd cmd;
    bba_pkg::t_dp_sts sts;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bba_dpath #(.TOTAL_LOG2(TOTAL_LOG2)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_in.operation),
        .i_request_size  (i_in.request_size),
        .i_block_offset  (i_in.block_offset),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_status        (o_out.status),
        .o_result_offset (o_out.result_offset),
        .o_result_size   (o_out.result_size)
    );
endmodule

/* rtl/bba_chk.sv */
`timescale 1ns / 1ps
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator.
module bba_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [bba_pkg::ST_W-1:0]    i_status,
    input logic [bba_pkg::OFF_W-1:0]   i_result_offset,
    input logic [bba_pkg::REQ_W-1:0]   i_result_size
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_result_offset) && $stable(i_result_size))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while another is in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != bba_pkg::ST_OK |->
            i_result_offset == '0 && i_result_size == '0)
        else $error("error result carries a block");

    a_ok_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == bba_pkg::ST_OK |-> $onehot0(i_result_size))
        else $error("block size not a power of two");
endmodule

bind buddy_block_allocator bba_chk u_bba_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_result_offset (o_out.result_offset),
    .i_result_size   (o_out.result_size)
);
